// ----- rtl/irn_pkg.sv -----
// ----------------------------------------------------------------------------
// irn_pkg: shared types and constants for the nearest-neighbor image rotator
// Widths, codes, sequencer states and the control bundle that the sequencer
// hands to the arithmetic datapath.
// ----------------------------------------------------------------------------
package irn_pkg;

  // Frame store geometry.
  localparam int MAX_WIDTH       = 256;
  localparam int MAX_HEIGHT      = 256;
  localparam int COL_W           = $clog2(MAX_WIDTH);
  localparam int ROW_W           = $clog2(MAX_HEIGHT);
  localparam int ADDR_W          = COL_W + ROW_W;
  localparam int STORE_DEPTH     = 1 << ADDR_W;

  // Field widths.
  localparam int PIX_W           = 24;
  localparam int COEFF_W         = 16;
  localparam int DIM_W           = 9;
  localparam int POS_W           = 9;
  localparam int BMIN_W          = POS_W + 1;
  localparam int COEFF_FRAC_BITS = 14;

  // Smallest usable source size on either axis.
  localparam int MIN_DIM         = 3;

  // Compare width that holds a clamped size and a load counter plus one.
  localparam int LD_W  = ((COL_W > ROW_W) ? COL_W : ROW_W) + 1;
  localparam int CMP_W = (LD_W > DIM_W) ? LD_W : DIM_W;

  // Shared multiplier operands: A carries a size or a mapped coordinate,
  // B carries a coefficient with room for the negated sine.
  localparam int OPA_W  = (POS_W + 2 > CMP_W + 1) ? POS_W + 2 : CMP_W + 1;
  localparam int OPB_W  = COEFF_W + 1;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = PROD_W + 1;

  localparam logic signed [ACC_W-1:0] Q_ONE = ACC_W'(1) << COEFF_FRAC_BITS;

  // The background pixel sits at row 2, column 2 of the source.
  localparam int BG_POS = 2;
  localparam logic [ADDR_W-1:0] BG_ADDR = {ROW_W'(BG_POS), COL_W'(BG_POS)};

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEFF_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS    = 3'd0,
    CFG_SIN    = 3'd1,
    CFG_CCW    = 3'd2,
    CFG_WIDTH  = 3'd3,
    CFG_HEIGHT = 3'd4
  } irn_cfg_t;

  localparam logic signed [COEFF_W-1:0] COS_RESET    = 16'sd16384;
  localparam logic signed [COEFF_W-1:0] SIN_RESET    = 16'sd0;
  localparam logic [DIM_W-1:0]          WIDTH_RESET  = 9'd256;
  localparam logic [DIM_W-1:0]          HEIGHT_RESET = 9'd256;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } irn_op_t;

  typedef struct packed {
    irn_op_t          opcode;
    logic [PIX_W-1:0] src_pixel;
  } irn_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic [POS_W-1:0] out_col;
    logic [POS_W-1:0] out_row;
    logic             last_of_frame;
  } irn_out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_B0, ST_B1, ST_B2, ST_B3, ST_B4, ST_B5, ST_B6, ST_B7, ST_B8,
    ST_MX,
    ST_M0, ST_M1, ST_M2, ST_M3, ST_M4,
    ST_RD
  } irn_state_t;

  typedef enum logic [1:0] {
    A_WID,
    A_HGT,
    A_X,
    A_Y
  } irn_opa_t;

  typedef enum logic {
    B_COS,
    B_SIN
  } irn_opb_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_NEG,
    ACC_ADD,
    ACC_SUB
  } irn_acc_op_t;

  typedef enum logic [1:0] {
    MM_P,
    MM_NEGP,
    MM_ACC
  } irn_mm_src_t;

  typedef struct packed {
    irn_opa_t    mul_a;
    irn_opb_t    mul_b;
    irn_acc_op_t ax_op;
    irn_acc_op_t ay_op;
    logic        mm_clear;
    logic        mm_en;
    logic        mm_y;
    irn_mm_src_t mm_src;
    logic        fin_en;
    logic        fin_y;
    logic        xy_load;
    logic        rd;
  } irn_ctrl_t;

endpackage

// ----- rtl/irn_store.sv -----
// ----------------------------------------------------------------------------
// irn_store: source frame store
// One write port for loading and one read port with registered read data.
// ----------------------------------------------------------------------------
module irn_store
  import irn_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [PIX_W-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [PIX_W-1:0]  rdata
);

  logic [PIX_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/irn_seq.sv -----
// ----------------------------------------------------------------------------
// irn_seq: step sequencer for the rotator
// Walks the bounding-box steps at the start of a frame, then the four
// multiplies of the inverse mapping and the store read for every fetch.
// ----------------------------------------------------------------------------
module irn_seq
  import irn_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      fetch_go,
  input  logic      frame_start,
  output logic      busy,
  output irn_ctrl_t ctrl
);

  irn_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (fetch_go) begin
          state_next = frame_start ? ST_B0 : ST_MX;
        end
      end
      ST_B0:   state_next = ST_B1;
      ST_B1:   state_next = ST_B2;
      ST_B2:   state_next = ST_B3;
      ST_B3:   state_next = ST_B4;
      ST_B4:   state_next = ST_B5;
      ST_B5:   state_next = ST_B6;
      ST_B6:   state_next = ST_B7;
      ST_B7:   state_next = ST_B8;
      ST_B8:   state_next = ST_MX;
      ST_MX:   state_next = ST_M0;
      ST_M0:   state_next = ST_M1;
      ST_M1:   state_next = ST_M2;
      ST_M2:   state_next = ST_M3;
      ST_M3:   state_next = ST_M4;
      ST_M4:   state_next = ST_RD;
      ST_RD:   state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '{mul_a: A_WID, mul_b: B_COS, ax_op: ACC_HOLD, ay_op: ACC_HOLD,
             mm_clear: 1'b0, mm_en: 1'b0, mm_y: 1'b0, mm_src: MM_P,
             fin_en: 1'b0, fin_y: 1'b0, xy_load: 1'b0, rd: 1'b0};
    busy = (state != ST_IDLE);
    case (state)
      // Corner products W*c, W*s, H*s, H*c feed the running extremes.
      ST_B0: begin
        ctrl.mul_a    = A_WID;
        ctrl.mul_b    = B_COS;
        ctrl.mm_clear = 1'b1;
      end
      ST_B1: begin
        ctrl.ax_op  = ACC_LOAD;
        ctrl.mm_en  = 1'b1;
        ctrl.mm_src = MM_P;
        ctrl.mul_a  = A_WID;
        ctrl.mul_b  = B_SIN;
      end
      ST_B2: begin
        ctrl.ay_op  = ACC_NEG;
        ctrl.mm_en  = 1'b1;
        ctrl.mm_y   = 1'b1;
        ctrl.mm_src = MM_NEGP;
        ctrl.mul_a  = A_HGT;
        ctrl.mul_b  = B_SIN;
      end
      ST_B3: begin
        ctrl.ax_op  = ACC_ADD;
        ctrl.mm_en  = 1'b1;
        ctrl.mm_src = MM_P;
        ctrl.mul_a  = A_HGT;
        ctrl.mul_b  = B_COS;
      end
      ST_B4: begin
        ctrl.ay_op  = ACC_ADD;
        ctrl.mm_en  = 1'b1;
        ctrl.mm_y   = 1'b1;
        ctrl.mm_src = MM_P;
      end
      ST_B5: begin
        ctrl.mm_en  = 1'b1;
        ctrl.mm_src = MM_ACC;
      end
      ST_B6: begin
        ctrl.mm_en  = 1'b1;
        ctrl.mm_y   = 1'b1;
        ctrl.mm_src = MM_ACC;
      end
      ST_B7: begin
        ctrl.fin_en = 1'b1;
      end
      ST_B8: begin
        ctrl.fin_en = 1'b1;
        ctrl.fin_y  = 1'b1;
      end
      ST_MX: begin
        ctrl.xy_load = 1'b1;
      end
      // x = X*c - Y*s, y = X*s + Y*c through the one multiplier.
      ST_M0: begin
        ctrl.mul_a = A_X;
        ctrl.mul_b = B_COS;
      end
      ST_M1: begin
        ctrl.ax_op = ACC_LOAD;
        ctrl.mul_a = A_Y;
        ctrl.mul_b = B_SIN;
      end
      ST_M2: begin
        ctrl.ax_op = ACC_SUB;
        ctrl.mul_a = A_X;
        ctrl.mul_b = B_SIN;
      end
      ST_M3: begin
        ctrl.ay_op = ACC_LOAD;
        ctrl.mul_a = A_Y;
        ctrl.mul_b = B_COS;
      end
      ST_M4: begin
        ctrl.ay_op = ACC_ADD;
      end
      ST_RD: begin
        ctrl.rd = 1'b1;
      end
      default: begin
        ctrl.rd = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/irn_dpath.sv -----
// ----------------------------------------------------------------------------
// irn_dpath: shared multiplier, accumulators and box logic
// One registered signed multiplier serves both the corner products and the
// inverse mapping; the accumulators and extremes sit behind it.
// ----------------------------------------------------------------------------
module irn_dpath
  import irn_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  irn_ctrl_t                 ctrl,
  input  logic signed [COEFF_W-1:0] cos_coeff,
  input  logic signed [COEFF_W-1:0] sin_coeff,
  input  logic                      ccw,
  input  logic [CMP_W-1:0]          w_eff,
  input  logic [CMP_W-1:0]          h_eff,
  input  logic [POS_W-1:0]          emit_col,
  input  logic [POS_W-1:0]          emit_row,
  output logic [POS_W-1:0]          box_cols,
  output logic [POS_W-1:0]          box_rows,
  output logic [ADDR_W-1:0]         rd_addr
);

  logic signed [OPB_W-1:0]  c_val, s_raw, s_val, op_b;
  logic signed [OPA_W-1:0]  op_a, xy_x, xy_y;
  logic signed [PROD_W-1:0] p;
  logic signed [ACC_W-1:0]  p_ext, ax, ay, ax_next, ay_next;
  logic signed [ACC_W-1:0]  mnx, mxx, mny, mxy, cand, cur_mn, cur_mx;
  logic signed [ACC_W-1:0]  fin_mn, fin_mx, min_r, len_r, w_ext, h_ext;
  logic signed [ACC_W-1:0]  ax_q, ay_q;
  logic signed [BMIN_W-1:0] box_min_x, box_min_y, min_sat;
  logic [POS_W-1:0]         len_sat;
  logic                     min_fits, x_ok, y_ok;
  logic [COL_W-1:0]         x_idx;
  logic [ROW_W-1:0]         y_idx;

  assign c_val = {cos_coeff[COEFF_W-1], cos_coeff};
  assign s_raw = {sin_coeff[COEFF_W-1], sin_coeff};
  assign s_val = ccw ? s_raw : -s_raw;

  always_comb begin
    case (ctrl.mul_a)
      A_WID:   op_a = $signed({{(OPA_W-CMP_W){1'b0}}, w_eff});
      A_HGT:   op_a = $signed({{(OPA_W-CMP_W){1'b0}}, h_eff});
      A_X:     op_a = xy_x;
      A_Y:     op_a = xy_y;
      default: op_a = '0;
    endcase
  end

  assign op_b = (ctrl.mul_b == B_COS) ? c_val : s_val;

  always_ff @(posedge clk) begin
    p <= op_a * op_b;
  end

  assign p_ext = {p[PROD_W-1], p};

  always_comb begin
    case (ctrl.ax_op)
      ACC_LOAD: ax_next = p_ext;
      ACC_NEG:  ax_next = -p_ext;
      ACC_ADD:  ax_next = ax + p_ext;
      ACC_SUB:  ax_next = ax - p_ext;
      default:  ax_next = ax;
    endcase
    case (ctrl.ay_op)
      ACC_LOAD: ay_next = p_ext;
      ACC_NEG:  ay_next = -p_ext;
      ACC_ADD:  ay_next = ay + p_ext;
      ACC_SUB:  ay_next = ay - p_ext;
      default:  ay_next = ay;
    endcase
  end

  always_ff @(posedge clk) begin
    ax <= ax_next;
    ay <= ay_next;
  end

  // Running extremes of the rotated corners, the origin included.
  always_comb begin
    case (ctrl.mm_src)
      MM_P:    cand = p_ext;
      MM_NEGP: cand = -p_ext;
      MM_ACC:  cand = ctrl.mm_y ? ay : ax;
      default: cand = p_ext;
    endcase
    cur_mn = ctrl.mm_y ? mny : mnx;
    cur_mx = ctrl.mm_y ? mxy : mxx;
  end

  always_ff @(posedge clk) begin
    if (ctrl.mm_clear) begin
      mnx <= '0;
      mxx <= '0;
      mny <= '0;
      mxy <= '0;
    end else if (ctrl.mm_en) begin
      if (ctrl.mm_y) begin
        mny <= (cand < cur_mn) ? cand : cur_mn;
        mxy <= (cand > cur_mx) ? cand : cur_mx;
      end else begin
        mnx <= (cand < cur_mn) ? cand : cur_mn;
        mxx <= (cand > cur_mx) ? cand : cur_mx;
      end
    end
  end

  // Box origin is floor(min) + 1, box length floor(max - min) + 2, both
  // saturated to their field ranges.
  always_comb begin
    fin_mn   = ctrl.fin_y ? mny : mnx;
    fin_mx   = ctrl.fin_y ? mxy : mxx;
    min_r    = (fin_mn >>> COEFF_FRAC_BITS) + ACC_W'(1);
    len_r    = ((fin_mx - fin_mn) >>> COEFF_FRAC_BITS) + ACC_W'(2);
    min_fits = (&min_r[ACC_W-1:BMIN_W-1]) | ~(|min_r[ACC_W-1:BMIN_W-1]);
    if (min_fits) begin
      min_sat = min_r[BMIN_W-1:0];
    end else if (min_r[ACC_W-1]) begin
      min_sat = {1'b1, {(BMIN_W-1){1'b0}}};
    end else begin
      min_sat = {1'b0, {(BMIN_W-1){1'b1}}};
    end
    if (|len_r[ACC_W-1:POS_W]) begin
      len_sat = '1;
    end else begin
      len_sat = len_r[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_min_x <= '0;
      box_min_y <= '0;
      box_cols  <= '0;
      box_rows  <= '0;
    end else if (ctrl.fin_en) begin
      if (ctrl.fin_y) begin
        box_min_y <= min_sat;
        box_rows  <= len_sat;
      end else begin
        box_min_x <= min_sat;
        box_cols  <= len_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.xy_load) begin
      xy_x <= $signed({{(OPA_W-POS_W){1'b0}}, emit_col})
            + $signed({{(OPA_W-BMIN_W){box_min_x[BMIN_W-1]}}, box_min_x});
      xy_y <= $signed({{(OPA_W-POS_W){1'b0}}, emit_row})
            + $signed({{(OPA_W-BMIN_W){box_min_y[BMIN_W-1]}}, box_min_y});
    end
  end

  // Truncation toward zero: a value above minus one maps to a coordinate
  // of at least zero, and negative values in that band land on zero.
  always_comb begin
    w_ext = $signed({{(ACC_W-CMP_W){1'b0}}, w_eff});
    h_ext = $signed({{(ACC_W-CMP_W){1'b0}}, h_eff});
    ax_q  = ax >>> COEFF_FRAC_BITS;
    ay_q  = ay >>> COEFF_FRAC_BITS;
    x_ok  = (ax > -Q_ONE) && (ax[ACC_W-1] || (ax_q < w_ext));
    y_ok  = (ay > -Q_ONE) && (ay[ACC_W-1] || (ay_q < h_ext));
    x_idx = ax[ACC_W-1] ? '0 : ax_q[COL_W-1:0];
    y_idx = ay[ACC_W-1] ? '0 : ay_q[ROW_W-1:0];
    rd_addr = (x_ok && y_ok) ? {y_idx, x_idx} : BG_ADDR;
  end

endmodule

// ----- rtl/image_rotate_nearest.sv -----
// ----------------------------------------------------------------------------
// image_rotate_nearest: nearest-neighbor frame rotator
// A load beat fills the source frame store in raster order; a fetch beat
// produces the next pixel of the rotated frame in raster order.
// ----------------------------------------------------------------------------
// A load beat does not raise busy, so loads may be issued back to back. A
// fetch beat keeps busy high through the mapping steps and the store read,
// its result appears on the following cycle, and no new beat is taken
// until busy falls; the first fetch of each rotated frame also computes
// the bounding box. Fetch time is set by the single signed multiplier,
// which forms four products per output pixel (and four corner products
// per frame), and by the registered read of the frame store. Each result
// is shown for exactly one cycle with done high and cannot be held off, so
// the receiver must take it then. The frame store is not cleared at reset;
// its contents are undefined until loaded, and configuration may only be
// written while busy is low and no result is pending.
// ----------------------------------------------------------------------------
module image_rotate_nearest
  import irn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  irn_in_t               cmd,
  output logic                  done,
  output irn_out_t              result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic signed [COEFF_W-1:0] cos_coeff, sin_coeff;
  logic                      counterclockwise;
  logic [DIM_W-1:0]          src_width, src_height;

  // Sizes clamped to the usable range; they are read live.
  logic [CMP_W-1:0] w_eff, h_eff, w_ext, h_ext;

  // Raster counters for loading and for the rotated frame.
  logic [COL_W-1:0] load_col;
  logic [ROW_W-1:0] load_row;
  logic [CMP_W-1:0] lc_inc, lr_inc;
  logic [POS_W-1:0] emit_col, emit_row, box_cols, box_rows;
  logic [POS_W:0]   ec_inc, er_inc;
  logic             last_pix;

  // Result bookkeeping.
  logic [POS_W-1:0] res_col, res_row;
  logic             res_last;
  logic [PIX_W-1:0] store_q;

  logic              accept, load_go, fetch_go, frame_start;
  logic [ADDR_W-1:0] rd_addr;
  irn_ctrl_t         ctrl;

  assign accept   = start && !busy;
  assign load_go  = accept && (cmd.opcode == OP_LOAD);
  assign fetch_go = accept && (cmd.opcode == OP_FETCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_coeff        <= COS_RESET;
      sin_coeff        <= SIN_RESET;
      counterclockwise <= 1'b1;
      src_width        <= WIDTH_RESET;
      src_height       <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COS:    cos_coeff        <= cfg_data;
        CFG_SIN:    sin_coeff        <= cfg_data;
        CFG_CCW:    counterclockwise <= cfg_data[0];
        CFG_WIDTH:  src_width        <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT: src_height       <= cfg_data[DIM_W-1:0];
        default:    counterclockwise <= counterclockwise;
      endcase
    end
  end

  always_comb begin
    w_ext = CMP_W'(src_width);
    h_ext = CMP_W'(src_height);
    if (w_ext < CMP_W'(MIN_DIM)) begin
      w_eff = CMP_W'(MIN_DIM);
    end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext < CMP_W'(MIN_DIM)) begin
      h_eff = CMP_W'(MIN_DIM);
    end else if (h_ext > CMP_W'(MAX_HEIGHT)) begin
      h_eff = CMP_W'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
  end

  // Load position advances in raster order. If the size was lowered under
  // the current position, the write still lands there and the next advance
  // wraps.
  assign lc_inc = CMP_W'(load_col) + CMP_W'(1);
  assign lr_inc = CMP_W'(load_row) + CMP_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_col <= '0;
      load_row <= '0;
    end else if (load_go) begin
      if (lc_inc >= w_eff) begin
        load_col <= '0;
        load_row <= (lr_inc >= h_eff) ? '0 : lr_inc[ROW_W-1:0];
      end else begin
        load_col <= lc_inc[COL_W-1:0];
      end
    end
  end

  // Output position walks the bounding box; the box is recomputed whenever
  // a fetch starts at the top-left corner.
  assign frame_start = (emit_col == '0) && (emit_row == '0);
  assign ec_inc      = {1'b0, emit_col} + (POS_W+1)'(1);
  assign er_inc      = {1'b0, emit_row} + (POS_W+1)'(1);
  assign last_pix    = (ec_inc >= {1'b0, box_cols}) && (er_inc >= {1'b0, box_rows});

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_col <= '0;
      emit_row <= '0;
    end else if (ctrl.rd) begin
      if (ec_inc >= {1'b0, box_cols}) begin
        emit_col <= '0;
        emit_row <= (er_inc >= {1'b0, box_rows}) ? '0 : er_inc[POS_W-1:0];
      end else begin
        emit_col <= ec_inc[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      res_col  <= emit_col;
      res_row  <= emit_row;
      res_last <= last_pix;
    end
  end

  always_comb begin
    result.out_pixel     = store_q;
    result.out_col       = res_col;
    result.out_row       = res_row;
    result.last_of_frame = res_last;
  end

  irn_store u_store (
    .clk   (clk),
    .we    (load_go),
    .waddr ({load_row, load_col}),
    .wdata (cmd.src_pixel),
    .re    (ctrl.rd),
    .raddr (rd_addr),
    .rdata (store_q)
  );

  irn_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .fetch_go    (fetch_go),
    .frame_start (frame_start),
    .busy        (busy),
    .ctrl        (ctrl)
  );

  irn_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cos_coeff (cos_coeff),
    .sin_coeff (sin_coeff),
    .ccw       (counterclockwise),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .emit_col  (emit_col),
    .emit_row  (emit_row),
    .box_cols  (box_cols),
    .box_rows  (box_rows),
    .rd_addr   (rd_addr)
  );

  // A result beat always lands in a cycle where a new beat can be taken.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while the sequencer is busy");

  // A load never produces a result.
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    load_go |=> !done)
    else $error("result strobe right after a load beat");

  // A fetch occupies the sequencer on the next cycle.
  a_fetch_busy: assert property (@(posedge clk) disable iff (rst)
    fetch_go |=> busy)
    else $error("fetch beat did not start the sequencer");

  // Once a box exists, the output column stays inside it.
  a_col_in_box: assert property (@(posedge clk) disable iff (rst)
    (box_cols != '0) |-> (emit_col < box_cols))
    else $error("output column outside the bounding box");

endmodule
